FILE: src/pem_pkg.sv
package pem_pkg;

	localparam int MaxWidth  = 1024;
	localparam int MaxHeight = 4096;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int FwW       = ColW + 1;
	localparam int FhW       = RowW + 1;
	localparam int PixW      = 8;
	localparam int GradW     = 11;
	localparam int AbsW      = 10;
	localparam int SumW      = 2 * AbsW + 1;

	localparam logic [FwW-1:0] WidthReset  = FwW'(640);
	localparam logic [FhW-1:0] HeightReset = FhW'(480);

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic            action;
		logic [PixW-1:0] pixel;
	} in_item_t;

	typedef struct packed {
		logic [PixW-1:0] magnitude;
		logic [RowW-1:0] out_row;
		logic [ColW-1:0] out_col;
		logic            frame_last;
	} out_item_t;

	typedef struct packed {
		logic signed [GradW-1:0] gx;
		logic signed [GradW-1:0] gy;
		logic [RowW-1:0]         row;
		logic [ColW-1:0]         col;
		logic                    last;
	} grad_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_PX_WAIT,
		F_PX_WIN,
		F_PX_EMIT,
		F_DR_READ,
		F_DR_EMIT
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SQUARE,
		B_ROOT,
		B_DONE
	} back_state_t;

endpackage

FILE: src/pem_front.sv
module pem_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  pem_pkg::in_item_t     in_item,
	output logic                  in_stall,
	input  logic                  cfg_clear,
	input  logic [pem_pkg::FwW-1:0] eff_w,
	input  logic [pem_pkg::FhW-1:0] eff_h,
	input  pem_pkg::q_stat_t      q_stat,
	output logic                  q_push,
	output pem_pkg::grad_t        q_data
);

	pem_pkg::front_state_t state_q, state_d;

	logic [pem_pkg::PixW-1:0] up_mem [pem_pkg::MaxWidth];
	logic [pem_pkg::PixW-1:0] lo_mem [pem_pkg::MaxWidth];
	logic [pem_pkg::PixW-1:0] up_rd_q, lo_rd_q;
	logic [pem_pkg::ColW-1:0] rd_addr_q;

	logic [pem_pkg::ColW-1:0] in_col_q, emit_col_q;
	logic [pem_pkg::RowW-1:0] in_row_q, emit_row_q;
	logic                     draining_q;
	logic [pem_pkg::PixW-1:0] win_q [9];
	logic [1:0]               dcnt_q;

	logic [pem_pkg::PixW-1:0] px_q;
	logic [pem_pkg::ColW-1:0] a_q, ahi_q, ex_q;
	logic [pem_pkg::RowW-1:0] arow_q;
	logic [pem_pkg::PixW-1:0] dup_q [3];
	logic [pem_pkg::PixW-1:0] dlo_q [3];

	logic [1:0]               k;
	logic [pem_pkg::FwW-1:0]  w_m1;
	logic [pem_pkg::FhW-1:0]  h_m1;
	logic                     accept;
	logic                     mem_we;
	logic [pem_pkg::PixW-1:0] g [3][3];
	logic [pem_pkg::PixW-1:0] col_new [3];
	logic signed [pem_pkg::GradW-1:0] gx, gy;
	logic                     last_x;
	logic                     emit_any;
	logic                     drain_ok;

	function automatic logic [pem_pkg::ColW-1:0] clamp_col(
		input logic [pem_pkg::FwW-1:0] c,
		input logic [pem_pkg::FwW-1:0] wm1
	);
		logic [pem_pkg::FwW-1:0] r;
		r = (c > wm1) ? wm1 : c;
		return r[pem_pkg::ColW-1:0];
	endfunction

	assign k      = (eff_h >= pem_pkg::FhW'(3)) ? 2'd2 : 2'(eff_h - pem_pkg::FhW'(1));
	assign w_m1   = eff_w - pem_pkg::FwW'(1);
	assign h_m1   = eff_h - pem_pkg::FhW'(1);
	assign accept = in_valid && !in_stall;
	assign mem_we = (state_q == pem_pkg::F_PX_WIN);
	assign last_x = ({1'b0, in_col_q} == w_m1);
	assign emit_any = ({1'b0, in_row_q} >= pem_pkg::FhW'(k))
		&& ((in_col_q >= pem_pkg::ColW'(2)) || last_x);
	assign drain_ok = draining_q && ({1'b0, emit_col_q} < eff_w)
		&& ({1'b0, emit_row_q} < eff_h);

	always_ff @(posedge clk) begin
		up_rd_q <= up_mem[rd_addr_q];
		lo_rd_q <= lo_mem[rd_addr_q];
		if (mem_we) begin
			up_mem[in_col_q] <= lo_rd_q;
			lo_mem[in_col_q] <= px_q;
		end
	end

	// new window column by how many rows the frame has
	always_comb begin
		unique case (k)
			2'd2: begin
				col_new[0] = up_rd_q; col_new[1] = lo_rd_q; col_new[2] = px_q;
			end
			2'd1: begin
				col_new[0] = lo_rd_q; col_new[1] = px_q; col_new[2] = px_q;
			end
			default: begin
				col_new[0] = px_q; col_new[1] = px_q; col_new[2] = px_q;
			end
		endcase
	end

	// gather the 3x3 neighborhood for the result being pushed
	always_comb begin
		logic [pem_pkg::FwW-1:0] c;
		logic [pem_pkg::FwW-1:0] diff;
		logic [1:0]              idx;
		for (int d = 0; d < 3; d++) begin
			c = {1'b0, a_q} + pem_pkg::FwW'(d);
			if (c > {1'b0, ex_q})
				c = {1'b0, ex_q};
			diff = {1'b0, ex_q} - c;
			idx  = 2'd2 - diff[1:0];
			for (int i = 0; i < 3; i++)
				g[i][d] = (state_q == pem_pkg::F_DR_EMIT)
					? ((i == 0 && {1'b0, emit_row_q} != h_m1) ? dup_q[d] : dlo_q[d])
					: win_q[3 * i + 32'(idx)];
		end
	end

	always_comb begin
		gx = '0;
		gy = '0;
		for (int i = 0; i < 3; i++) begin
			gx = gx + $signed({3'b000, g[i][2]}) - $signed({3'b000, g[i][0]});
			gy = gy + $signed({3'b000, g[2][i]}) - $signed({3'b000, g[0][i]});
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != pem_pkg::F_IDLE);
		q_push   = 1'b0;
		q_data.gx = gx;
		q_data.gy = gy;
		if (state_q == pem_pkg::F_DR_EMIT) begin
			q_data.row  = emit_row_q;
			q_data.col  = emit_col_q;
			q_data.last = ({1'b0, emit_row_q} == h_m1) && ({1'b0, emit_col_q} == w_m1);
		end else begin
			q_data.row  = arow_q;
			q_data.col  = a_q;
			q_data.last = ({1'b0, arow_q} == h_m1) && ({1'b0, a_q} == w_m1);
		end
		unique case (state_q)
			pem_pkg::F_IDLE: begin
				if (accept) begin
					if (in_item.action == pem_pkg::ACT_PIXEL)
						state_d = pem_pkg::F_PX_WAIT;
					else if (drain_ok)
						state_d = pem_pkg::F_DR_READ;
				end
			end
			pem_pkg::F_PX_WAIT: state_d = pem_pkg::F_PX_WIN;
			pem_pkg::F_PX_WIN:  state_d = emit_any ? pem_pkg::F_PX_EMIT : pem_pkg::F_IDLE;
			pem_pkg::F_PX_EMIT: begin
				if (!q_stat.full) begin
					q_push = 1'b1;
					if (a_q == ahi_q)
						state_d = pem_pkg::F_IDLE;
				end
			end
			pem_pkg::F_DR_READ: begin
				if (dcnt_q == 2'd3)
					state_d = pem_pkg::F_DR_EMIT;
			end
			pem_pkg::F_DR_EMIT: begin
				if (!q_stat.full) begin
					q_push  = 1'b1;
					state_d = pem_pkg::F_IDLE;
				end
			end
			default: state_d = pem_pkg::F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pem_pkg::F_IDLE;
			in_col_q   <= '0;
			in_row_q   <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
			draining_q <= 1'b0;
			dcnt_q     <= '0;
			rd_addr_q  <= '0;
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_clear) begin
				in_col_q   <= '0;
				in_row_q   <= '0;
				emit_col_q <= '0;
				emit_row_q <= '0;
				draining_q <= 1'b0;
			end else begin
				unique case (state_q)
					pem_pkg::F_IDLE: begin
						if (accept) begin
							if (in_item.action == pem_pkg::ACT_PIXEL) begin
								draining_q <= 1'b0;
								rd_addr_q  <= in_col_q;
							end else if (!drain_ok) begin
								draining_q <= 1'b0;
							end else begin
								rd_addr_q <= emit_col_q;
								dcnt_q    <= '0;
							end
						end
					end
					pem_pkg::F_PX_WIN: begin
						for (int i = 0; i < 3; i++) begin
							win_q[3 * i]     <= win_q[3 * i + 1];
							win_q[3 * i + 1] <= win_q[3 * i + 2];
							win_q[3 * i + 2] <= col_new[i];
						end
						// advance the input position
						if ({1'b0, in_col_q} + pem_pkg::FwW'(1) >= eff_w) begin
							in_col_q <= '0;
							if ({1'b0, in_row_q} + pem_pkg::FhW'(1) >= eff_h) begin
								in_row_q <= '0;
								if (k != 2'd0) begin
									draining_q <= 1'b1;
									emit_row_q <= pem_pkg::RowW'(eff_h - pem_pkg::FhW'(k));
									emit_col_q <= '0;
								end
							end else begin
								in_row_q <= in_row_q + pem_pkg::RowW'(1);
							end
						end else begin
							in_col_q <= in_col_q + pem_pkg::ColW'(1);
						end
					end
					pem_pkg::F_DR_READ: begin
						rd_addr_q <= clamp_col({1'b0, emit_col_q}
							+ pem_pkg::FwW'(dcnt_q) + pem_pkg::FwW'(1), w_m1);
						dcnt_q <= dcnt_q + 2'd1;
					end
					pem_pkg::F_DR_EMIT: begin
						if (!q_stat.full) begin
							if ({1'b0, emit_col_q} + pem_pkg::FwW'(1) >= eff_w) begin
								emit_col_q <= '0;
								emit_row_q <= emit_row_q + pem_pkg::RowW'(1);
								if ({1'b0, emit_row_q} + pem_pkg::FhW'(1) >= eff_h)
									draining_q <= 1'b0;
							end else begin
								emit_col_q <= emit_col_q + pem_pkg::ColW'(1);
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == pem_pkg::F_IDLE && accept)
			px_q <= in_item.pixel;
		if (state_q == pem_pkg::F_PX_WIN) begin
			ex_q   <= in_col_q;
			arow_q <= in_row_q - pem_pkg::RowW'(k);
			if (last_x) begin
				a_q   <= (in_col_q >= pem_pkg::ColW'(2)) ? in_col_q - pem_pkg::ColW'(2) : '0;
				ahi_q <= in_col_q;
			end else begin
				a_q   <= in_col_q - pem_pkg::ColW'(2);
				ahi_q <= in_col_q - pem_pkg::ColW'(2);
			end
		end
		// advance the anchor on each pixel-result push
		if (state_q == pem_pkg::F_PX_EMIT && !q_stat.full)
			a_q <= a_q + pem_pkg::ColW'(1);
		if (state_q == pem_pkg::F_DR_READ && dcnt_q != 2'd0) begin
			dup_q[dcnt_q - 2'd1] <= up_rd_q;
			dlo_q[dcnt_q - 2'd1] <= lo_rd_q;
		end
	end

endmodule

FILE: src/pem_fifo.sv
module pem_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pem_pkg::grad_t   push_data,
	input  logic             pop,
	output pem_pkg::grad_t   pop_data,
	output pem_pkg::q_stat_t stat
);

	pem_pkg::grad_t mem_q [2];
	logic           wr_q, rd_q;
	logic [1:0]     count_q;

	assign pop_data   = mem_q[rd_q];
	assign stat.full  = (count_q == 2'd2);
	assign stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (pop)
				rd_q <= !rd_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: src/pem_back.sv
module pem_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pem_pkg::q_stat_t   q_stat,
	input  pem_pkg::grad_t     q_data,
	output logic               q_pop,
	output logic               out_valid,
	output pem_pkg::out_item_t out_item,
	input  logic               out_stall
);

	pem_pkg::back_state_t state_q, state_d;

	pem_pkg::grad_t            ent_q;
	logic [pem_pkg::SumW-1:0]  sum_q;
	logic [pem_pkg::PixW-1:0]  root_q;
	logic [2:0]                bit_q;
	logic                      out_valid_q;
	pem_pkg::out_item_t        out_q;

	logic [pem_pkg::AbsW-1:0]  ax, ay;
	logic [pem_pkg::GradW-1:0] nx, ny;
	logic [pem_pkg::PixW-1:0]  trial;
	logic [2*pem_pkg::PixW-1:0] trial_sq;
	logic                      sat;
	logic                      load;

	assign nx  = ent_q.gx[pem_pkg::GradW-1] ? -ent_q.gx : ent_q.gx;
	assign ny  = ent_q.gy[pem_pkg::GradW-1] ? -ent_q.gy : ent_q.gy;
	assign ax  = nx[pem_pkg::AbsW-1:0];
	assign ay  = ny[pem_pkg::AbsW-1:0];
	assign sat = (sum_q[pem_pkg::SumW-1:2*pem_pkg::PixW] != '0);
	assign trial    = root_q | (pem_pkg::PixW'(1) << bit_q);
	assign trial_sq = trial * trial;
	assign load     = (state_q == pem_pkg::B_DONE) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		unique case (state_q)
			pem_pkg::B_IDLE: begin
				if (!q_stat.empty) begin
					q_pop   = 1'b1;
					state_d = pem_pkg::B_SQUARE;
				end
			end
			pem_pkg::B_SQUARE: state_d = pem_pkg::B_ROOT;
			pem_pkg::B_ROOT: begin
				if (sat || bit_q == 3'd0)
					state_d = pem_pkg::B_DONE;
			end
			pem_pkg::B_DONE: begin
				if (load)
					state_d = pem_pkg::B_IDLE;
			end
			default: state_d = pem_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pem_pkg::B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// one result bit per cycle, most significant first
	always_ff @(posedge clk) begin
		if (q_pop)
			ent_q <= q_data;
		if (state_q == pem_pkg::B_SQUARE) begin
			sum_q  <= pem_pkg::SumW'(ax) * pem_pkg::SumW'(ax)
				+ pem_pkg::SumW'(ay) * pem_pkg::SumW'(ay);
			root_q <= '0;
			bit_q  <= 3'd7;
		end
		if (state_q == pem_pkg::B_ROOT) begin
			if (sat)
				root_q <= '1;
			else if (trial_sq <= sum_q[2*pem_pkg::PixW-1:0])
				root_q <= trial;
			bit_q <= bit_q - 3'd1;
		end
		if (load) begin
			out_q.magnitude  <= root_q;
			out_q.out_row    <= ent_q.row;
			out_q.out_col    <= ent_q.col;
			out_q.frame_last <= ent_q.last;
		end
	end

endmodule

FILE: src/prewitt_edge_magnitude_top.sv
// Prewitt 3x3 gradient magnitude over a raster stream of 8-bit grey pixels.
// Input channel (in_valid/in_stall/in_item): action 0 carries a pixel, action
// 1 is a drain tick that emits one of the last rows' results after a frame.
// Output channel (out_valid/out_stall/out_item): magnitude, anchor row and
// column, and frame_last on the final result of the frame.
// A pixel holds the input through accept, line-buffer read and window
// update, and then while it pushes each of its results; a drain tick holds
// it through its line-buffer reads and its push. The line buffers have one
// read port and read one column per cycle. The result side takes one result
// at a time (pop, square, an 8-step bit-serial square root, output load;
// fewer steps when the sum saturates), so a row-end pixel that makes three
// results is bounded by that unit.
// A two-entry queue separates the window side from the root unit, and the
// output register lets the next result be worked while one waits.
// Reset clears the frame position, the window and the queue; the line
// buffers need no clearing. Width and height reset to 640 and 480; any
// register write starts a new frame. A stalled receiver fills the queue
// and then holds the input side.
module prewitt_edge_magnitude_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pem_pkg::in_item_t  in_item,
	output logic               in_stall,
	output logic               out_valid,
	output pem_pkg::out_item_t out_item,
	input  logic               out_stall,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [pem_pkg::FwW-1:0] width_q, eff_w;
	logic [pem_pkg::FhW-1:0] height_q, eff_h;
	logic                    cfg_wr;
	logic                    q_push, q_pop;
	pem_pkg::grad_t          push_data, pop_data;
	pem_pkg::q_stat_t        q_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == pem_pkg::REG_HEIGHT)
		? 32'(height_q) : 32'(width_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= pem_pkg::WidthReset;
			height_q <= pem_pkg::HeightReset;
		end else if (cfg_wr) begin
			if (paddr[2] == pem_pkg::REG_WIDTH)
				width_q <= pwdata[pem_pkg::FwW-1:0];
			else
				height_q <= pwdata[pem_pkg::FhW-1:0];
		end
	end

	// saturate the frame size to the supported range
	assign eff_w = (width_q == '0) ? pem_pkg::FwW'(1)
		: (width_q > pem_pkg::FwW'(pem_pkg::MaxWidth)) ? pem_pkg::FwW'(pem_pkg::MaxWidth)
		: width_q;
	assign eff_h = (height_q == '0) ? pem_pkg::FhW'(1)
		: (height_q > pem_pkg::FhW'(pem_pkg::MaxHeight)) ? pem_pkg::FhW'(pem_pkg::MaxHeight)
		: height_q;

	pem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.in_stall  (in_stall),
		.cfg_clear (cfg_wr),
		.eff_w     (eff_w),
		.eff_h     (eff_h),
		.q_stat    (q_stat),
		.q_push    (q_push),
		.q_data    (push_data)
	);

	pem_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	pem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_data    (pop_data),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_item  (out_item),
		.out_stall (out_stall)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("queue pop while empty");

	a_push_then_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |=> !q_stat.empty)
		else $error("queue lost a pushed item");

endmodule
